// File: rtl/core/ura_pkg.sv
// Shared types and constants for the USB audio rate feedback block.
package ura_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned RATE_SHIFT = 10;
  localparam int unsigned IIR_SHIFT = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IDX_NOMINAL = 3'd0;
  localparam cfg_idx_t CFG_IDX_FILL_SETPOINT = 3'd1;
  localparam cfg_idx_t CFG_IDX_SERVO_GAIN = 3'd2;
  localparam cfg_idx_t CFG_IDX_SERVO_CLAMP = 3'd3;
  localparam cfg_idx_t CFG_IDX_OUTER_CLAMP = 3'd4;

  localparam logic [31:0] NOMINAL_RST = 32'd786432;
  localparam logic [7:0] FILL_SETPOINT_RST = 8'd8;
  localparam logic [15:0] SERVO_GAIN_RST = 16'd1024;
  localparam logic [15:0] SERVO_CLAMP_RST = 16'd8192;
  localparam logic [15:0] OUTER_CLAMP_RST = 16'd16384;

  typedef struct packed {
    logic [31:0] nominal_feedback;
    logic [7:0]  fill_setpoint;
    logic [15:0] servo_gain;
    logic [15:0] servo_clamp;
    logic [15:0] outer_clamp;
  } cfg_t;

  typedef struct packed {
    logic [31:0] words_total;
    logic [7:0]  fill_level;
    logic [31:0] restart_value;
  } item_t;

  typedef struct packed {
    logic [31:0] feedback_value;
    logic        updated;
  } res_t;

endpackage

// File: rtl/core/ura_cfg_regs.sv
// Configuration register file for the rate feedback block.
module ura_cfg_regs import ura_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nominal_feedback <= NOMINAL_RST;
      cfg_r.fill_setpoint <= FILL_SETPOINT_RST;
      cfg_r.servo_gain <= SERVO_GAIN_RST;
      cfg_r.servo_clamp <= SERVO_CLAMP_RST;
      cfg_r.outer_clamp <= OUTER_CLAMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_NOMINAL: cfg_r.nominal_feedback <= cfg_wdata;
        CFG_IDX_FILL_SETPOINT: cfg_r.fill_setpoint <= cfg_wdata[7:0];
        CFG_IDX_SERVO_GAIN: cfg_r.servo_gain <= cfg_wdata[15:0];
        CFG_IDX_SERVO_CLAMP: cfg_r.servo_clamp <= cfg_wdata[15:0];
        CFG_IDX_OUTER_CLAMP: cfg_r.outer_clamp <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/ura_rate_update.sv
// Rate state registers and the per-tick filter, servo and clamp datapath.
module ura_rate_update import ura_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [1:0]  phase_r;
  logic [31:0] last_total_r;
  logic [31:0] filtered_r;
  logic [31:0] feedback_r;

  logic [1:0]  phase_nxt;
  logic [31:0] last_total_nxt;
  logic [31:0] filtered_nxt;
  logic [31:0] feedback_nxt;

  logic               restart;
  logic [1:0]         phase_base;
  logic [31:0]        total_base;
  logic [31:0]        filt_base;
  logic               measure;
  logic [31:0]        delta;
  logic [31:0]        raw;
  logic signed [32:0] diff;
  logic signed [32:0] step;
  logic [32:0]        filt_sum;
  logic [31:0]        filt_new;
  logic signed [8:0]  fill_err;
  logic signed [25:0] prod;
  logic signed [25:0] servo_raw;
  logic signed [25:0] clamp_pos;
  logic signed [25:0] clamp_neg;
  logic signed [25:0] servo;
  logic signed [33:0] sum;
  logic signed [33:0] hi;
  logic signed [33:0] lo;
  logic signed [33:0] sum_cl;
  logic               do_update;

  always_comb begin
    restart = (item.restart_value != 32'd0);
    phase_base = restart ? 2'd0 : phase_r;
    total_base = restart ? item.words_total : last_total_r;
    filt_base = restart ? item.restart_value : filtered_r;
    phase_nxt = phase_base + 2'd1;
    measure = (phase_nxt == 2'd0);
    delta = item.words_total - total_base;
    last_total_nxt = measure ? item.words_total : total_base;
    do_update = measure && (delta != 32'd0);

    raw = {delta[31-RATE_SHIFT:0], {RATE_SHIFT{1'b0}}};
    // floor division by 8 via arithmetic shift
    diff = $signed({1'b0, raw}) - $signed({1'b0, filt_base});
    step = diff >>> IIR_SHIFT;
    filt_sum = {1'b0, filt_base} + step;
    filt_new = (filt_base == 32'd0) ? raw : filt_sum[31:0];
    filtered_nxt = do_update ? filt_new : filt_base;

    fill_err = $signed({1'b0, item.fill_level}) - $signed({1'b0, cfg.fill_setpoint});
    prod = 26'(fill_err * $signed({1'b0, cfg.servo_gain}));
    servo_raw = -prod;
    clamp_pos = $signed({10'd0, cfg.servo_clamp});
    clamp_neg = -clamp_pos;
    if (servo_raw > clamp_pos) begin
      servo = clamp_pos;
    end else if (servo_raw < clamp_neg) begin
      servo = clamp_neg;
    end else begin
      servo = servo_raw;
    end

    sum = $signed({2'b00, filt_new}) + $signed({{8{servo[25]}}, servo});
    hi = $signed({2'b00, cfg.nominal_feedback}) + $signed({18'd0, cfg.outer_clamp});
    lo = $signed({2'b00, cfg.nominal_feedback}) - $signed({18'd0, cfg.outer_clamp});
    sum_cl = sum;
    if (sum_cl > hi) sum_cl = hi;
    if (sum_cl < lo) sum_cl = lo;
    if (sum_cl[33]) begin
      feedback_nxt = 32'd0;
    end else if (sum_cl[32]) begin
      feedback_nxt = 32'hFFFF_FFFF;
    end else begin
      feedback_nxt = sum_cl[31:0];
    end
    if (!do_update) feedback_nxt = feedback_r;

    res.feedback_value = feedback_nxt;
    res.updated = do_update;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      last_total_r <= 32'd0;
      filtered_r <= 32'd0;
      feedback_r <= NOMINAL_RST;
    end else if (fire) begin
      phase_r <= phase_nxt;
      last_total_r <= last_total_nxt;
      filtered_r <= filtered_nxt;
      feedback_r <= feedback_nxt;
    end
  end

endmodule

// File: rtl/core/usb_audio_rate_feedback_core.sv
// An accepted word goes from the input register to the result register, which drives
// the output. Throughput: one word per cycle while out_stall does not hold a result;
// the two registers form a two-stage pipeline, and the rate state updates as a word
// leaves stage one. Reset (rst_n low, synchronous): pipeline empties, tick phase, last
// count and filter clear, feedback returns to nominal, registers return to defaults.
module usb_audio_rate_feedback_core import ura_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_words_total,
  input  logic [7:0]            in_fill_level,
  input  logic [31:0]           in_restart_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_feedback_value,
  output logic                  out_updated
);

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_valid_r;
  res_t  res;
  res_t  out_res_r;
  logic  out_valid_r;
  logic  adv;
  logic  in_acc;

  ura_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ura_rate_update u_rate (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign adv = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.words_total <= in_words_total;
      s1_item_r.fill_level <= in_fill_level;
      s1_item_r.restart_value <= in_restart_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_feedback_value = out_res_r.feedback_value;
  assign out_updated = out_res_r.updated;

endmodule

// File: verif/usb_audio_rate_feedback_core_tb.sv
// Self-checking testbench for the USB audio rate feedback core.
module usb_audio_rate_feedback_core_tb;
  import ura_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam cfg_idx_t CFG_IDX_SPARE = 3'd7;
  localparam longint U32_MAX = 64'h0000_0000_FFFF_FFFF;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [31:0]           in_words_total;
  logic [7:0]            in_fill_level;
  logic [31:0]           in_restart_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [31:0]           out_feedback_value;
  logic                  out_updated;

  // shadow of the rate state and registers
  cfg_t        cur_cfg;
  logic [1:0]  meas_phase;
  logic [31:0] prev_total;
  logic [31:0] rate_filter;
  logic [31:0] feedback_now;

  res_t        feedback_expect_q[$];
  int          mismatch_count;
  int          stuck_cycles;
  int          src_idle_pct;
  int          sink_stall_pct;
  logic [31:0] stream_total;

  usb_audio_rate_feedback_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_words_total(in_words_total),
    .in_fill_level(in_fill_level),
    .in_restart_value(in_restart_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_feedback_value(out_feedback_value),
    .out_updated(out_updated)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (int'($urandom_range(99)) < sink_stall_pct);
  end

  task automatic predict_feedback(input item_t w, output res_t r);
    logic [31:0] delta;
    logic [31:0] raw;
    longint diff, servo, sum, hi, lo;
    r.updated = 1'b0;
    if (w.restart_value != 32'd0) begin
      rate_filter = w.restart_value;
      prev_total = w.words_total;
      meas_phase = 2'd0;
    end
    meas_phase = meas_phase + 2'd1;
    if (meas_phase == 2'd0) begin
      delta = w.words_total - prev_total;
      prev_total = w.words_total;
      if (delta != 32'd0) begin
        raw = delta << RATE_SHIFT;
        if (rate_filter == 32'd0) begin
          rate_filter = raw;
        end else begin
          // arithmetic shift of the exact difference: floor division by 8
          diff = longint'(raw) - longint'(rate_filter);
          rate_filter = 32'(longint'(rate_filter) + (diff >>> IIR_SHIFT));
        end
        servo = -((longint'(w.fill_level) - longint'(cur_cfg.fill_setpoint))
                  * longint'(cur_cfg.servo_gain));
        if (servo > longint'(cur_cfg.servo_clamp)) servo = longint'(cur_cfg.servo_clamp);
        if (servo < -longint'(cur_cfg.servo_clamp)) servo = -longint'(cur_cfg.servo_clamp);
        sum = longint'(rate_filter) + servo;
        hi = longint'(cur_cfg.nominal_feedback) + longint'(cur_cfg.outer_clamp);
        lo = longint'(cur_cfg.nominal_feedback) - longint'(cur_cfg.outer_clamp);
        if (sum > hi) sum = hi;
        if (sum < lo) sum = lo;
        if (sum < 0) sum = 0;
        if (sum > U32_MAX) sum = U32_MAX;
        feedback_now = sum[31:0];
        r.updated = 1'b1;
      end
    end
    r.feedback_value = feedback_now;
  endtask

  // result check, prediction on input accept, and the watchdog
  always @(posedge clk) begin
    item_t w;
    res_t  want;
    res_t  pred;
    bit    moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (feedback_expect_q.size() == 0) begin
          $error("unexpected result word: feedback_value=%0h updated=%0b",
                 out_feedback_value, out_updated);
          mismatch_count++;
        end else begin
          want = feedback_expect_q.pop_front();
          if (out_feedback_value !== want.feedback_value) begin
            $error("feedback_value: expected %0h, got %0h",
                   want.feedback_value, out_feedback_value);
            mismatch_count++;
          end
          if (out_updated !== want.updated) begin
            $error("updated: expected %0b, got %0b", want.updated, out_updated);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        w.words_total = in_words_total;
        w.fill_level = in_fill_level;
        w.restart_value = in_restart_value;
        predict_feedback(w, pred);
        feedback_expect_q.push_back(pred);
      end
    end
    if (moved) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic [31:0] total, input logic [7:0] fill,
                           input logic [31:0] restart);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_words_total <= total;
    in_fill_level <= fill;
    in_restart_value <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (feedback_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_IDX_NOMINAL:       cur_cfg.nominal_feedback = data;
      CFG_IDX_FILL_SETPOINT: cur_cfg.fill_setpoint = data[7:0];
      CFG_IDX_SERVO_GAIN:    cur_cfg.servo_gain = data[15:0];
      CFG_IDX_SERVO_CLAMP:   cur_cfg.servo_clamp = data[15:0];
      CFG_IDX_OUTER_CLAMP:   cur_cfg.outer_clamp = data[15:0];
      default: ;
    endcase
  endtask

  // junk in the upper bits of narrow registers must be dropped
  task automatic cfg_apply(input cfg_t c);
    logic [31:0] junk;
    junk = $urandom();
    cfg_write(CFG_IDX_NOMINAL, c.nominal_feedback);
    cfg_write(CFG_IDX_FILL_SETPOINT, {junk[31:8], c.fill_setpoint});
    cfg_write(CFG_IDX_SERVO_GAIN, {junk[15:0], c.servo_gain});
    cfg_write(CFG_IDX_SERVO_CLAMP, {junk[31:16], c.servo_clamp});
    cfg_write(CFG_IDX_OUTER_CLAMP, {junk[23:8], c.outer_clamp});
    cfg_write(CFG_IDX_SPARE, $urandom());
    cfg_we <= 1'b0;
  endtask

  // mostly realistic SOF streams near nominal, plus stalls, restarts and noise
  task automatic run_stream(input int n_words);
    int sent, kind, f, step, burst;
    logic [31:0] restart;
    sent = 0;
    step = int'(cur_cfg.nominal_feedback >> 12);
    while (sent < n_words) begin
      kind = int'($urandom_range(99));
      f = int'(cur_cfg.fill_setpoint) + int'($urandom_range(24)) - 12;
      if (f < 0) f = 0;
      if (f > 255) f = 255;
      if (kind < 72) begin
        stream_total = stream_total + 32'(step + int'($urandom_range(6)) - 3);
        restart = 32'd0;
        if ($urandom_range(99) < 3)
          restart = cur_cfg.nominal_feedback + 32'((int'($urandom_range(64)) - 32) * 256);
        send_tick(stream_total, 8'(f), restart);
        sent++;
      end else if (kind < 76) begin
        // consumer stopped: same count for a while, gives zero delta
        burst = int'($urandom_range(8, 4));
        repeat (burst) send_tick(stream_total, 8'(f), 32'd0);
        sent += burst;
      end else if (kind < 84) begin
        send_tick(stream_total, 8'(f), $urandom());
        sent++;
      end else begin
        stream_total = $urandom();
        restart = ($urandom_range(1) == 1) ? $urandom() : 32'd0;
        send_tick(stream_total, 8'($urandom()), restart);
        sent++;
      end
    end
  endtask

  task automatic test_special_cases();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    // measuring tick with nothing consumed
    repeat (4) send_tick(32'd0, 8'd8, 32'd0);
    // restart at nominal, empty buffers push servo to its positive limit
    send_tick(32'd1000, 8'd0, 32'd786432);
    send_tick(32'd1192, 8'd0, 32'd0);
    send_tick(32'd1384, 8'd0, 32'd0);
    send_tick(32'd1768, 8'd0, 32'd0);
    // full buffers, negative limit
    send_tick(32'd1960, 8'd255, 32'd0);
    send_tick(32'd2152, 8'd255, 32'd0);
    send_tick(32'd2344, 8'd255, 32'd0);
    send_tick(32'd2536, 8'd255, 32'd0);
    // raw rate wraps to zero and walks a filter of one down to unseeded
    send_tick(32'h0000_1000, 8'd8, 32'd1);
    send_tick(32'h0010_1000, 8'd8, 32'd0);
    send_tick(32'h0020_1000, 8'd8, 32'd0);
    send_tick(32'h0040_1000, 8'd8, 32'd0);
    // next measurement reseeds
    send_tick(32'h0040_10C0, 8'd8, 32'd0);
    send_tick(32'h0040_1180, 8'd8, 32'd0);
    send_tick(32'h0040_1240, 8'd8, 32'd0);
    send_tick(32'h0040_1300, 8'd8, 32'd0);
    // max restart and count, then the count wraps through zero
    send_tick(32'hFFFF_FFFF, 8'd200, 32'hFFFF_FFFF);
    send_tick(32'h0000_00BF, 8'd200, 32'd0);
    send_tick(32'h0000_017F, 8'd200, 32'd0);
    send_tick(32'h0000_02FF, 8'd200, 32'd0);
    stream_total = 32'h0000_02FF;
  endtask

  task automatic test_default_stream();
    wait_drain();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_stream(110);
  endtask

  task automatic test_high_extremes();
    cfg_t c;
    wait_drain();
    c.nominal_feedback = 32'hFFFF_FFFF;
    c.fill_setpoint = 8'hFF;
    c.servo_gain = 16'hFFFF;
    c.servo_clamp = 16'hFFFF;
    c.outer_clamp = 16'hFFFF;
    cfg_apply(c);
    src_idle_pct = 50;
    sink_stall_pct = 0;
    run_stream(110);
  endtask

  task automatic test_low_extremes();
    cfg_t c;
    wait_drain();
    // nominal below the outer clamp lets the lower bound fall under zero
    c.nominal_feedback = 32'd4096;
    c.fill_setpoint = 8'd0;
    c.servo_gain = 16'd0;
    c.servo_clamp = 16'd0;
    c.outer_clamp = 16'hFFFF;
    cfg_apply(c);
    src_idle_pct = 0;
    sink_stall_pct = 50;
    run_stream(55);
    wait_drain();
    c.nominal_feedback = 32'd0;
    c.outer_clamp = 16'd0;
    c.servo_gain = 16'd1;
    cfg_apply(c);
    run_stream(55);
  endtask

  task automatic test_random_config();
    cfg_t c;
    wait_drain();
    c.nominal_feedback = $urandom_range(32'h0100_0000, 32'h0001_0000);
    c.fill_setpoint = 8'($urandom());
    c.servo_gain = 16'($urandom());
    c.servo_clamp = 16'($urandom());
    c.outer_clamp = 16'($urandom());
    cfg_apply(c);
    src_idle_pct = 26;
    sink_stall_pct = 26;
    run_stream(110);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IDX_NOMINAL;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_words_total = '0;
    in_fill_level = '0;
    in_restart_value = '0;
    out_stall = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    mismatch_count = 0;
    stuck_cycles = 0;
    stream_total = '0;
    cur_cfg.nominal_feedback = NOMINAL_RST;
    cur_cfg.fill_setpoint = FILL_SETPOINT_RST;
    cur_cfg.servo_gain = SERVO_GAIN_RST;
    cur_cfg.servo_clamp = SERVO_CLAMP_RST;
    cur_cfg.outer_clamp = OUTER_CLAMP_RST;
    meas_phase = 2'd0;
    prev_total = '0;
    rate_filter = '0;
    feedback_now = NOMINAL_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_default_stream();
    test_high_extremes();
    test_low_extremes();
    test_random_config();
    wait_drain();

    if (mismatch_count == 0 && feedback_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ura_pkg.sv
rtl/core/ura_cfg_regs.sv
rtl/core/ura_rate_update.sv
rtl/core/usb_audio_rate_feedback_core.sv
verif/usb_audio_rate_feedback_core_tb.sv
